### rtl/lss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic push;       // shift data one cell down, top takes the new value
    logic pop;        // shift data one cell up
    logic load_hit;   // compare every cell against the key
    logic shift_hit;  // move match flags one cell towards the top
  } ctl_t;

endpackage

`default_nettype wire

### rtl/lss_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lss_cell (
  input  wire               clk,
  input  wire lss_pkg::ctl_t ctl,
  input  wire signed [31:0] key,
  input  wire signed [31:0] data_up,
  input  wire signed [31:0] data_dn,
  input  wire               hit_dn,
  output logic signed [31:0] data_o,
  output logic              hit_o
);

  logic signed [31:0] data_r;
  logic               hit_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data_r <= data_up;
    end else if (ctl.pop) begin
      data_r <= data_dn;
    end
    if (ctl.load_hit) begin
      hit_r <= (data_r == key);
    end else if (ctl.shift_hit) begin
      hit_r <= hit_dn;
    end
  end

  assign data_o = data_r;
  assign hit_o  = hit_r;

endmodule

`default_nettype wire

### rtl/lss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lss_ctrl #(
  parameter int DEPTH = 256
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire        [1:0]  in_mode,
  input  wire signed [31:0] top_data,
  input  wire               top_hit,
  output lss_pkg::ctl_t     ctl,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [31:0] out_popped_value,
  output logic              out_found,
  output logic       [7:0]  out_found_position,
  output logic       [1:0]  out_status,
  output logic       [8:0]  out_count,
  output logic              out_empty_res
);

  import lss_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] k_r, k_nxt;

  logic accept, is_full, is_empty, srch_done, srch_found;
  logic res_wr;
  logic signed [31:0] res_popped;
  logic [1:0]    res_status;
  logic [CW-1:0] res_pos;
  logic [CW+7:0] pos_ext;
  logic [CW+8:0] cnt_ext;

  logic               out_valid_r;
  logic signed [31:0] popped_r;
  logic               found_r;
  logic [7:0]         pos_r;
  logic [1:0]         status_r;
  logic [CW-1:0]      cnt_out_r;

  assign accept     = in_valid && in_ready;
  assign is_full    = (cnt_r == FULL);
  assign is_empty   = (cnt_r == '0);
  // top flag is only meaningful while the walk is still inside the stack
  assign srch_found = (k_r != cnt_r) && top_hit;
  assign srch_done  = (k_r == cnt_r) || top_hit;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_mode == MODE_SEARCH) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (srch_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctl           = '0;
    res_wr        = 1'b0;
    res_popped    = '0;
    res_status    = ST_OK;
    res_pos       = '0;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    case (state_r)
      S_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        k_nxt    = '0;
        if (accept) begin
          case (in_mode)
            MODE_PUSH: begin
              res_wr = 1'b1;
              if (is_full) begin
                res_status = ST_OVERFLOW;
              end else begin
                ctl.push = 1'b1;
                cnt_nxt  = cnt_r + ONE;
              end
            end
            MODE_POP: begin
              res_wr = 1'b1;
              if (is_empty) begin
                res_status = ST_UNDERFLOW;
              end else begin
                ctl.pop    = 1'b1;
                res_popped = top_data;
                cnt_nxt    = cnt_r - ONE;
              end
            end
            MODE_SEARCH: ctl.load_hit = 1'b1;
            default: res_wr = 1'b1;
          endcase
        end
      end
      S_SEARCH: begin
        if (srch_done) begin
          res_wr = 1'b1;
          if (srch_found) res_pos = cnt_r - ONE - k_r;
        end else begin
          ctl.shift_hit = 1'b1;
          k_nxt         = k_r + ONE;
        end
      end
      default: ;
    endcase
  end

  assign pos_ext = {8'b0, res_pos};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      if (res_wr) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      popped_r  <= res_popped;
      found_r   <= (state_r == S_SEARCH) && srch_found;
      pos_r     <= pos_ext[7:0];
      status_r  <= res_status;
      cnt_out_r <= cnt_nxt;
    end
  end

  assign cnt_ext            = {9'b0, cnt_out_r};
  assign out_valid          = out_valid_r;
  assign out_popped_value   = popped_r;
  assign out_found          = found_r;
  assign out_found_position = pos_r;
  assign out_status         = status_r;
  assign out_count          = cnt_ext[8:0];
  assign out_empty_res      = (cnt_out_r == '0);

endmodule

`default_nettype wire

### rtl/searchable_lifo_stack.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Beat contents
// in_      in         in_valid/in_ready    in_mode, in_value
// out_     out        out_valid/out_ready  popped_value, found, found_position,
//                                          status, count, empty_res
//
// Push, pop and the unused mode act when the beat is taken; the result is registered
// and shows the cycle after the beat is taken.
// A search loads the match flags when the beat is taken; the flags then
// walk one cell a cycle up the chain towards the top until they reach the
// topmost match, or until the whole fill count has passed when nothing matches.
// One request at a time; a new beat is taken while the previous result is
// being drained, but not while a search walks or the output is stalled.
// Reset clears the fill count and control only; cell contents are not reset.

module searchable_lifo_stack #(
  parameter int DEPTH = 256
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire        [1:0]  in_mode,
  input  wire signed [31:0] in_value,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [31:0] out_popped_value,
  output logic              out_found,
  output logic       [7:0]  out_found_position,
  output logic       [1:0]  out_status,
  output logic       [8:0]  out_count,
  output logic              out_empty_res
);

  import lss_pkg::*;

  ctl_t ctl;
  logic signed [31:0] data_w [DEPTH];
  logic               hit_w  [DEPTH];

  // cell 0 is the top of stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] up_w;
    logic signed [31:0] dn_w;
    logic               hdn_w;
    if (i == 0) begin : g_top
      assign up_w = in_value;
    end else begin : g_mid
      assign up_w = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign dn_w  = '0;
      assign hdn_w = 1'b0;
    end else begin : g_inner
      assign dn_w  = data_w[i+1];
      assign hdn_w = hit_w[i+1];
    end
    lss_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .key     (in_value),
      .data_up (up_w),
      .data_dn (dn_w),
      .hit_dn  (hdn_w),
      .data_o  (data_w[i]),
      .hit_o   (hit_w[i])
    );
  end

  lss_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .top_data           (data_w[0]),
    .top_hit            (hit_w[0]),
    .ctl                (ctl),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_popped_value   (out_popped_value),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .out_status         (out_status),
    .out_count          (out_count),
    .out_empty_res      (out_empty_res)
  );

endmodule

`default_nettype wire

### rtl/lss_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lss_checker (
  input wire              clk,
  input wire              rst_n,
  input wire              out_valid,
  input wire              out_ready,
  input wire signed [31:0] out_popped_value,
  input wire              out_found,
  input wire       [7:0]  out_found_position,
  input wire       [1:0]  out_status,
  input wire       [8:0]  out_count,
  input wire              out_empty_res
);

  import lss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_popped_value) &&
      $stable(out_status) && $stable(out_count))
    else $error("result beat changed while stalled");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_count == 9'd0)
    else $error("empty flag with non-zero count");

  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNDERFLOW |->
      out_empty_res && out_popped_value == 32'sd0 && !out_found)
    else $error("underflow beat not clean");

  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_position == 8'd0)
    else $error("position set without a match");

endmodule

bind searchable_lifo_stack lss_checker u_lss_checker (.*);

`default_nettype wire

### verif/searchable_lifo_stack_checker.sv
`timescale 1ns / 1ps

module searchable_lifo_stack_checker #(
  parameter int DEPTH = 256
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_ready,
  input  wire        [1:0]  in_mode,
  input  wire signed [31:0] in_value,
  input  wire               out_valid,
  input  wire               out_ready,
  input  wire signed [31:0] out_popped_value,
  input  wire               out_found,
  input  wire        [7:0]  out_found_position,
  input  wire        [1:0]  out_status,
  input  wire        [8:0]  out_count,
  input  wire               out_empty_res,
  output int                mismatches,
  output int                awaiting,
  output int                search_hits,
  output int                overflows,
  output int                underflows,
  output int                peak_fill
);
  import lss_pkg::*;

  typedef struct packed {
    logic signed [31:0] popped;
    logic               found;
    logic        [7:0]  position;
    logic        [1:0]  status;
    logic        [8:0]  count;
    logic               empty;
  } stack_result_t;

  logic [31:0]   cells [DEPTH];
  int            fill;
  int            errs;
  int            hits;
  int            n_over;
  int            n_under;
  int            fill_max;
  stack_result_t expected_q [$];

  function automatic stack_result_t apply_request(input logic [1:0] mode,
                                                  input logic [31:0] key);
    stack_result_t r;
    int            i;
    r = '0;
    r.status = ST_OK;
    case (mode)
      MODE_PUSH: begin
        if (fill >= DEPTH) begin
          r.status = ST_OVERFLOW;
          n_over++;
        end else begin
          cells[fill] = key;
          fill++;
        end
      end
      MODE_POP: begin
        if (fill == 0) begin
          r.status = ST_UNDERFLOW;
          n_under++;
        end else begin
          fill--;
          r.popped = cells[fill];
        end
      end
      MODE_SEARCH: begin
        // nearest match from the top down
        i = fill - 1;
        while (i >= 0 && !r.found) begin
          if (cells[i] == key) begin
            r.found = 1'b1;
            r.position = i[7:0];
            hits++;
          end
          i--;
        end
      end
      default: ;
    endcase
    if (fill > fill_max) fill_max = fill;
    r.count = fill[8:0];
    r.empty = (fill == 0);
    return r;
  endfunction

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    stack_result_t want;
    if (!rst_n) begin
      fill = 0;
      expected_q.delete();
    end else begin
      // result beat first: it always belongs to an earlier request beat
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no request outstanding");
          errs++;
        end else begin
          want = expected_q.pop_front();
          check_field("popped_value", longint'(want.popped), longint'(out_popped_value));
          check_field("found", want.found, out_found);
          check_field("found_position", want.position, out_found_position);
          check_field("status", want.status, out_status);
          check_field("count", want.count, out_count);
          check_field("empty_res", want.empty, out_empty_res);
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(apply_request(in_mode, in_value));
    end
    mismatches  <= errs;
    awaiting    <= expected_q.size();
    search_hits <= hits;
    overflows   <= n_over;
    underflows  <= n_under;
    peak_fill   <= fill_max;
  end

endmodule

### verif/searchable_lifo_stack_tb.sv
`timescale 1ns / 1ps

module searchable_lifo_stack_tb;
  import lss_pkg::*;

  localparam int          STACK_DEPTH = 256;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam logic [31:0] VAL_MIN     = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_ONES    = 32'hFFFF_FFFF;
  localparam int          SEGMENT_LEN = 110;
  localparam int          SEGMENTS    = 15;

  typedef enum int {
    LEAN_MIXED,
    LEAN_FILL,
    LEAN_DRAIN,
    LEAN_SEARCH
  } lean_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic        [1:0]  in_mode = MODE_PUSH;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_popped_value;
  logic               out_found;
  logic        [7:0]  out_found_position;
  logic        [1:0]  out_status;
  logic        [8:0]  out_count;
  logic               out_empty_res;

  // set for a long stretch during which neither side idles
  logic               calm = 1'b0;
  logic [31:0]        value_pool [16];
  int                 sent;
  int                 directed;

  int mismatches, awaiting, search_hits, overflows, underflows, peak_fill;

  searchable_lifo_stack #(
    .DEPTH(STACK_DEPTH)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_popped_value  (out_popped_value),
    .out_found         (out_found),
    .out_found_position(out_found_position),
    .out_status        (out_status),
    .out_count         (out_count),
    .out_empty_res     (out_empty_res)
  );

  searchable_lifo_stack_checker #(
    .DEPTH(STACK_DEPTH)
  ) stack_watch (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_popped_value  (out_popped_value),
    .out_found         (out_found),
    .out_found_position(out_found_position),
    .out_status        (out_status),
    .out_count         (out_count),
    .out_empty_res     (out_empty_res),
    .mismatches        (mismatches),
    .awaiting          (awaiting),
    .search_hits       (search_hits),
    .overflows         (overflows),
    .underflows        (underflows),
    .peak_fill         (peak_fill)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 30);
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic issue(input logic [1:0] mode, input logic [31:0] value);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return value_pool[$urandom_range(15)];
    if (roll < 90) return $urandom();
    case ($urandom_range(3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_ONES;
      default: return '0;
    endcase
  endfunction

  function automatic logic [1:0] pick_mode(input lean_t lean);
    int roll;
    int push_w;
    int pop_w;
    int search_w;
    roll = $urandom_range(99);
    case (lean)
      LEAN_FILL:   begin push_w = 88; pop_w = 4;  search_w = 7;  end
      LEAN_DRAIN:  begin push_w = 8;  pop_w = 80; search_w = 10; end
      LEAN_SEARCH: begin push_w = 40; pop_w = 10; search_w = 49; end
      default:     begin push_w = 40; pop_w = 35; search_w = 23; end
    endcase
    if (roll < push_w) return MODE_PUSH;
    if (roll < push_w + pop_w) return MODE_POP;
    if (roll < push_w + pop_w + search_w) return MODE_SEARCH;
    return MODE_UNUSED;
  endfunction

  // fill to full and hold, drain past empty, then go round again
  function automatic lean_t lean_of(input int seg);
    case (seg)
      1, 2, 3, 10, 11, 12: return LEAN_FILL;
      4:                   return LEAN_SEARCH;
      5, 6, 7, 8, 14:      return LEAN_DRAIN;
      default:             return LEAN_MIXED;
    endcase
  endfunction

  initial begin
    lean_t lean;
    for (int i = 0; i < 16; i++) value_pool[i] = $urandom();
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = VAL_ONES;
    value_pool[3] = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stack corners
    issue(MODE_POP, 32'h1234_5678);
    issue(MODE_SEARCH, '0);
    issue(MODE_UNUSED, VAL_ONES);
    // extremes, with a duplicate so the topmost match must win
    issue(MODE_PUSH, VAL_MIN);
    issue(MODE_PUSH, VAL_MAX);
    issue(MODE_PUSH, '0);
    issue(MODE_PUSH, VAL_ONES);
    issue(MODE_PUSH, VAL_MIN);
    issue(MODE_SEARCH, VAL_MIN);
    issue(MODE_SEARCH, VAL_MAX);
    issue(MODE_SEARCH, 32'h1234_5678);
    issue(MODE_SEARCH, VAL_ONES);
    issue(MODE_UNUSED, VAL_MAX);
    issue(MODE_POP, '0);
    issue(MODE_SEARCH, VAL_MIN);
    // drain right down, last entry included, then past empty
    repeat (4) issue(MODE_POP, VAL_ONES);
    issue(MODE_POP, '0);
    issue(MODE_PUSH, 32'hAAAA_AAAA);
    issue(MODE_PUSH, 32'h5555_5555);
    issue(MODE_SEARCH, 32'h5555_5555);
    issue(MODE_POP, '0);
    issue(MODE_POP, '0);
    directed = sent;

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      lean = lean_of(seg);
      calm <= (seg == 6 || seg == 7);
      for (int k = 0; k < SEGMENT_LEN; k++) issue(pick_mode(lean), pick_value());
    end

    in_valid <= 1'b0;
    calm     <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    // a full-depth miss is the slowest request
    repeat (STACK_DEPTH + 40) @(posedge clk);

    $display("Sent %0d requests (%0d directed), through fill to full, hold, drain past empty.",
             sent, directed);
    $display("Search hits %0d, push overflows %0d, pop underflows %0d, peak fill %0d of %0d.",
             search_hits, overflows, underflows, peak_fill, STACK_DEPTH);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
